[src/gktrim_pkg.sv]
// Shared types, constants and helpers for the gain knob trim block.
package gktrim_pkg;

  localparam int SPAN_US = 500;
  localparam int DEN = 2 * SPAN_US;

  localparam int MAG_W = 28;
  localparam int RECIP_SHIFT = MAG_W + $clog2(DEN);
  localparam int RECIP_W = MAG_W + 1;
  localparam longint RECIP_VAL = ((longint'(1) << RECIP_SHIFT) + longint'(DEN) - 1) /
                                 longint'(DEN);
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_VAL[RECIP_W-1:0];

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [15:0] RANGE_MAX = 16'd32768;
  localparam logic [11:0] NEUTRAL_RESET = 12'd1500;

  localparam logic        ENABLE_RESET = 1'b1;
  localparam logic [15:0] TRIM_RANGE_RESET = 16'd6554;
  localparam logic [15:0] HOLD_TICKS_RESET = 16'd1000;
  localparam logic [11:0] YAW_THRESHOLD_RESET = 12'd1150;

  typedef enum logic [1:0] {
    REG_ENABLE        = 2'd0,
    REG_TRIM_RANGE    = 2'd1,
    REG_HOLD_TICKS    = 2'd2,
    REG_YAW_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] kp_knob_us;
    logic [11:0] kd_knob_us;
    logic [11:0] yaw_us;
    logic        armed;
  } in_t;

  typedef struct packed {
    logic [15:0] kp_mult_q14;
    logic [15:0] kd_mult_q14;
    logic        save_now;
    logic [15:0] bake_kp_q14;
    logic [15:0] bake_kd_q14;
  } out_t;

  // Signed trim numerator split into sign and a floor-adjusted magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } trim_num_t;

  typedef struct packed {
    trim_num_t kp;
    trim_num_t kd;
    logic      save;
    logic      en;
  } stage_t;

  // range * (knob - neutral); negative magnitudes get DEN-1 added so a
  // plain floor of mag/DEN gives the ceiling, i.e. floor of the signed value.
  function automatic trim_num_t trim_prep(input logic [11:0] knob,
                                          input logic [11:0] neutral,
                                          input logic [15:0] range);
    logic [12:0]      d;
    logic [11:0]      ad;
    logic [MAG_W-1:0] prod;
    trim_num_t        r;
    d = {1'b0, knob} - {1'b0, neutral};
    ad = d[12] ? 12'(-d) : d[11:0];
    prod = MAG_W'(range) * MAG_W'(ad);
    r.neg = d[12];
    r.mag = d[12] ? prod + MAG_W'(DEN - 1) : prod;
    return r;
  endfunction

endpackage

[src/gktrim_scale.sv]
// Divides a trim numerator by the knob span, clamps and adds the 1.0 offset.
module gktrim_scale (
  input  gktrim_pkg::trim_num_t num,
  input  logic [14:0]           half,
  output logic [15:0]           mult
);
  import gktrim_pkg::*;

  localparam int PROD_W = MAG_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo_full;
  logic [MAG_W-1:0]  quo;
  logic [14:0]       quo_clamped;

  always_comb begin
    prod = PROD_W'(num.mag) * PROD_W'(RECIP_MUL);
    quo_full = prod >> RECIP_SHIFT;
    quo = quo_full[MAG_W-1:0];
    quo_clamped = (quo > MAG_W'(half)) ? half : quo[14:0];
    mult = num.neg ? ONE_Q14 - 16'(quo_clamped) : ONE_Q14 + 16'(quo_clamped);
  end

endmodule

[src/gain_knob_trim_with_save_gesture_unit.sv]
// Top level of the gain knob trim block with the disarmed yaw save gesture.
//
// One request per clock is taken and sustained for as long as the result side
// does not stall. Three register stages (input, trim product, result) each
// hold one request, so up to three requests are in flight and the input keeps
// taking requests while a finished result waits, until the input and trim
// product registers are full. The hold counter and both neutrals update in
// the cycle a request leaves the input register, so each request sees the
// state left by the one before it. Configuration writes are always ready and
// are meant to be made while no request is in flight.
module gain_knob_trim_with_save_gesture_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  gktrim_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output gktrim_pkg::out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import gktrim_pkg::*;

  logic        enable;
  logic [15:0] trim_range_q15;
  logic [15:0] hold_ticks;
  logic [11:0] yaw_threshold_us;

  logic [11:0] kp_neutral_us, kp_neutral_us_next;
  logic [11:0] kd_neutral_us, kd_neutral_us_next;
  logic [15:0] hold_count, hold_count_next;
  logic        save_latched, save_latched_next;

  logic   s0_valid;
  in_t    s0_data;
  logic   s1_valid;
  stage_t s1_data, s1_data_next;

  logic        in_take, s1_load, s2_load;
  logic [15:0] range;
  logic [14:0] half;
  logic        gesture;
  logic [15:0] hold_inc;
  logic        fire;
  logic [15:0] kp_calc, kd_calc;
  out_t        result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= ENABLE_RESET;
      trim_range_q15 <= TRIM_RANGE_RESET;
      hold_ticks <= HOLD_TICKS_RESET;
      yaw_threshold_us <= YAW_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:        enable <= cfg_data[0];
        REG_TRIM_RANGE:    trim_range_q15 <= cfg_data;
        REG_HOLD_TICKS:    hold_ticks <= cfg_data;
        REG_YAW_THRESHOLD: yaw_threshold_us <= cfg_data[11:0];
        default:           enable <= enable;
      endcase
    end
  end

  assign range = (trim_range_q15 > RANGE_MAX) ? RANGE_MAX : trim_range_q15;
  assign half = range[15:1];

  // Pipeline flow control
  assign s2_load = s1_valid && (!out_valid || !out_stall);
  assign s1_load = s0_valid && (!s1_valid || s2_load);
  assign in_stall = s0_valid && !s1_load;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s0_valid <= 1'b1;
      end else if (s1_load) begin
        s0_valid <= 1'b0;
      end
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Save gesture and neutral tracking
  always_comb begin
    gesture = !s0_data.armed && (s0_data.yaw_us != 12'd0) &&
              (s0_data.yaw_us < yaw_threshold_us);
    hold_inc = (hold_count < hold_ticks) ? hold_count + 16'd1 : hold_count;
    fire = enable && gesture && (hold_inc >= hold_ticks) && !save_latched;

    kp_neutral_us_next = kp_neutral_us;
    kd_neutral_us_next = kd_neutral_us;
    hold_count_next = 16'd0;
    save_latched_next = 1'b0;
    if (enable && gesture) begin
      hold_count_next = hold_inc;
      save_latched_next = save_latched || fire;
    end
    if (fire) begin
      kp_neutral_us_next = s0_data.kp_knob_us;
      kd_neutral_us_next = s0_data.kd_knob_us;
    end

    s1_data_next.kp = trim_prep(s0_data.kp_knob_us, kp_neutral_us, range);
    s1_data_next.kd = trim_prep(s0_data.kd_knob_us, kd_neutral_us, range);
    s1_data_next.save = fire;
    s1_data_next.en = enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_neutral_us <= NEUTRAL_RESET;
      kd_neutral_us <= NEUTRAL_RESET;
      hold_count <= 16'd0;
      save_latched <= 1'b0;
    end else if (s1_load) begin
      kp_neutral_us <= kp_neutral_us_next;
      kd_neutral_us <= kd_neutral_us_next;
      hold_count <= hold_count_next;
      save_latched <= save_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_data <= in_data;
    end
    if (s1_load) begin
      s1_data <= s1_data_next;
    end
    if (s2_load) begin
      out_data <= result;
    end
  end

  gktrim_scale u_scale_kp (
    .num  (s1_data.kp),
    .half (half),
    .mult (kp_calc)
  );

  gktrim_scale u_scale_kd (
    .num  (s1_data.kd),
    .half (half),
    .mult (kd_calc)
  );

  always_comb begin
    result.kp_mult_q14 = ONE_Q14;
    result.kd_mult_q14 = ONE_Q14;
    result.save_now = 1'b0;
    result.bake_kp_q14 = ONE_Q14;
    result.bake_kd_q14 = ONE_Q14;
    if (s1_data.en) begin
      if (s1_data.save) begin
        result.save_now = 1'b1;
        result.bake_kp_q14 = kp_calc;
        result.bake_kd_q14 = kd_calc;
      end else begin
        result.kp_mult_q14 = kp_calc;
        result.kd_mult_q14 = kd_calc;
      end
    end
  end

endmodule

[src/gktrim_checker.sv]
// Port-level checks for the gain knob trim block, bound to the top level.
module gktrim_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input gktrim_pkg::out_t out_data
);
  import gktrim_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_save_unity: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.save_now |->
      out_data.kp_mult_q14 == ONE_Q14 && out_data.kd_mult_q14 == ONE_Q14)
    else $error("save result without unity multipliers");

  a_bake_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.save_now |->
      out_data.bake_kp_q14 == ONE_Q14 && out_data.bake_kd_q14 == ONE_Q14)
    else $error("bake values without save");

  a_mult_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.kp_mult_q14 <= RANGE_MAX && out_data.kd_mult_q14 <= RANGE_MAX &&
      out_data.bake_kp_q14 <= RANGE_MAX && out_data.bake_kd_q14 <= RANGE_MAX)
    else $error("multiplier outside trim span");

endmodule

bind gain_knob_trim_with_save_gesture_unit gktrim_checker u_gktrim_checker (.*);

[test/testbench.sv]
// Self-checking bench for the gain knob trim unit: driver, monitor and a local gain predictor.
module testbench;
  import gktrim_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_ENABLE;
  logic [15:0] cfg_data = '0;

  gain_knob_trim_with_save_gesture_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of configuration and state.
  logic        en_m;
  logic [15:0] range_m;
  logic [15:0] hold_m;
  logic [11:0] thr_m;
  logic [11:0] kp_ntr;
  logic [11:0] kd_ntr;
  logic [15:0] hold_cnt;
  logic        latched;

  in_t  tick_q[$];
  out_t gain_q[$];
  int   queued_total = 0;
  int   taken_total = 0;
  int   mismatch_count = 0;
  int   quiet_cycles = 0;
  int   idle_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   holdoff_done = 0;
  bit   quiet_tail = 0;
  bit   in_taken = 0;

  function automatic logic [15:0] trim_gain(logic [11:0] knob, logic [11:0] neutral);
    longint rng, dlt, num, den, q, lo, hi, m;
    rng = (range_m > RANGE_MAX) ? longint'(RANGE_MAX) : longint'(range_m);
    dlt = longint'(knob) - longint'(neutral);
    num = rng * dlt;
    den = longint'(2 * SPAN_US);
    q = num / den;
    if ((num % den) != 0 && num < 0)
      q = q - 1;
    m = longint'(ONE_Q14) + q;
    lo = longint'(ONE_Q14) - rng / 2;
    hi = longint'(ONE_Q14) + rng / 2;
    if (lo < 0)
      lo = 0;
    if (m < lo)
      m = lo;
    if (m > hi)
      m = hi;
    return m[15:0];
  endfunction

  function automatic out_t predict_tick(in_t t);
    out_t r;
    logic [15:0] kpm, kdm;
    r.kp_mult_q14 = ONE_Q14;
    r.kd_mult_q14 = ONE_Q14;
    r.save_now = 1'b0;
    r.bake_kp_q14 = ONE_Q14;
    r.bake_kd_q14 = ONE_Q14;
    if (!en_m) begin
      hold_cnt = '0;
      latched = 1'b0;
    end else begin
      kpm = trim_gain(t.kp_knob_us, kp_ntr);
      kdm = trim_gain(t.kd_knob_us, kd_ntr);
      r.kp_mult_q14 = kpm;
      r.kd_mult_q14 = kdm;
      if (!t.armed && t.yaw_us != 0 && t.yaw_us < thr_m) begin
        if (hold_cnt < hold_m)
          hold_cnt = hold_cnt + 16'd1;
        if (hold_cnt >= hold_m && !latched) begin
          r.save_now = 1'b1;
          r.bake_kp_q14 = kpm;
          r.bake_kd_q14 = kdm;
          kp_ntr = t.kp_knob_us;
          kd_ntr = t.kd_knob_us;
          r.kp_mult_q14 = ONE_Q14;
          r.kd_mult_q14 = ONE_Q14;
          latched = 1'b1;
        end
      end else begin
        hold_cnt = '0;
        latched = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      gain_q.push_back(predict_tick(in_data));
      taken_total++;
      in_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 0;
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        idle_left = $urandom_range(1, 7) - 1;
        in_valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        in_data <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls plus one long hold-off to back the unit up.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (!holdoff_done && taken_total >= 400) begin
        holdoff_done = 1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (gain_q.size() == 0) begin
        flag_mismatch("result with nothing pending", out_data.kp_mult_q14, '0);
      end else begin
        want = gain_q.pop_front();
        if (out_data.kp_mult_q14 !== want.kp_mult_q14)
          flag_mismatch("kp_mult_q14", out_data.kp_mult_q14, want.kp_mult_q14);
        if (out_data.kd_mult_q14 !== want.kd_mult_q14)
          flag_mismatch("kd_mult_q14", out_data.kd_mult_q14, want.kd_mult_q14);
        if (out_data.save_now !== want.save_now)
          flag_mismatch("save_now", 16'(out_data.save_now), 16'(want.save_now));
        if (out_data.bake_kp_q14 !== want.bake_kp_q14)
          flag_mismatch("bake_kp_q14", out_data.bake_kp_q14, want.bake_kp_q14);
        if (out_data.bake_kd_q14 !== want.bake_kd_q14)
          flag_mismatch("bake_kd_q14", out_data.bake_kd_q14, want.bake_kd_q14);
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic add_tick(int kp, int kd, int yaw, int armed);
    in_t t;
    t.kp_knob_us = 12'(kp);
    t.kd_knob_us = 12'(kd);
    t.yaw_us = 12'(yaw);
    t.armed = armed[0];
    tick_q.push_back(t);
    queued_total++;
  endtask

  task automatic settle();
    while (taken_total != queued_total || gain_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      REG_ENABLE: en_m = v[0];
      REG_TRIM_RANGE: range_m = v;
      REG_HOLD_TICKS: hold_m = v;
      REG_YAW_THRESHOLD: thr_m = v[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_regs(bit en, int rng, int hold, int thr);
    settle();
    write_reg(REG_ENABLE, 16'(en));
    write_reg(REG_TRIM_RANGE, 16'(rng));
    write_reg(REG_HOLD_TICKS, 16'(hold));
    write_reg(REG_YAW_THRESHOLD, 16'(thr));
  endtask

  function automatic int pick_knob();
    if ($urandom_range(0, 1) == 0)
      return $urandom_range(0, 4095);
    return $urandom_range(900, 2100);
  endfunction

  // Mostly held gestures with random knobs, each ended by a release; some noise.
  task automatic queue_random(int n);
    int stop, len, cap, yaw_hi;
    stop = queued_total + n;
    cap = (hold_m > 12) ? 12 : int'(hold_m);
    yaw_hi = (thr_m > 1) ? int'(thr_m) - 1 : 1;
    while (queued_total < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, cap + 3);
        repeat (len)
          add_tick(pick_knob(), pick_knob(), $urandom_range(1, yaw_hi), 0);
        case ($urandom_range(0, 2))
          0: add_tick(pick_knob(), pick_knob(), 0, $urandom_range(0, 1));
          1: add_tick(pick_knob(), pick_knob(), $urandom_range(0, 4095), 1);
          default: add_tick(pick_knob(), pick_knob(), $urandom_range(thr_m, 4095), 0);
        endcase
      end else begin
        add_tick($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    en_m = ENABLE_RESET;
    range_m = TRIM_RANGE_RESET;
    hold_m = HOLD_TICKS_RESET;
    thr_m = YAW_THRESHOLD_RESET;
    kp_ntr = NEUTRAL_RESET;
    kd_ntr = NEUTRAL_RESET;
    hold_cnt = '0;
    latched = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: clamps, floor on negative offsets, armed block, fire and latch.
    program_regs(1, 6554, 2, 1150);
    add_tick(0, 4095, 1500, 0);
    add_tick(4095, 0, 0, 1);
    add_tick(1500, 1500, 4095, 0);
    add_tick(1499, 1501, 1500, 0);
    add_tick(1700, 1300, 1149, 1);
    add_tick(1800, 1200, 1, 0);
    add_tick(1800, 1200, 1, 0);
    add_tick(1750, 1250, 1, 0);
    add_tick(1600, 1400, 1150, 0);
    add_tick(4095, 0, 1149, 0);
    add_tick(4095, 0, 1149, 0);
    add_tick(0, 4095, 1000, 0);

    // Zero hold while a gesture carried over from the ticks before is still latched.
    program_regs(1, 32768, 0, 1150);
    add_tick(2000, 1000, 500, 0);
    add_tick(0, 4095, 1500, 0);

    // Hold lowered below the running count.
    program_regs(1, 65535, 10, 1150);
    repeat (5)
      add_tick(1300, 1700, 900, 0);
    settle();
    write_reg(REG_HOLD_TICKS, 16'd3);
    add_tick(1234, 1765, 900, 0);

    // Disabled mid-gesture, then range zero.
    program_regs(0, 6554, 2, 1150);
    add_tick(0, 4095, 600, 0);
    program_regs(1, 0, 2, 1150);
    add_tick(600, 3000, 600, 0);
    add_tick(4095, 0, 600, 0);

    program_regs(1, 6554, 3, 1150);
    queue_random(300);
    program_regs(1, 32768, 1, 4095);
    queue_random(250);
    program_regs(1, 65535, 5, 2000);
    queue_random(200);
    program_regs(1, 0, 2, 1150);
    queue_random(150);
    program_regs(0, 12345, 2, 1150);
    queue_random(100);
    program_regs(1, 1, 0, 4095);
    queue_random(100);
    program_regs(1, 20000, 65535, 0);
    queue_random(60);
    program_regs(1, $urandom_range(0, 65535), $urandom_range(1, 6), $urandom_range(1, 4095));
    quiet_tail = 1;
    queue_random(450);

    settle();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
src/gktrim_pkg.sv
src/gktrim_scale.sv
src/gain_knob_trim_with_save_gesture_unit.sv
src/gktrim_checker.sv
test/testbench.sv
